// ===== rtl/psma_pkg.sv =====
package psma_pkg;

    localparam int DEF_SLOTS  = 16;
    localparam int DEF_WINDOW = 5;

    // quotient bits resolved per divider cycle
    localparam int DIV_STEP_BITS = 4;

    localparam logic signed [15:0] LOW_RESET  = 16'sh8000;
    localparam logic signed [15:0] HIGH_RESET = 16'sh7FFF;

    localparam logic [1:0] CMD_MAP   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FILLING = 3'd1;
    localparam logic [2:0] ST_COLD    = 3'd2;
    localparam logic [2:0] ST_HOT     = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;
    localparam logic [2:0] ST_FULL    = 3'd5;
    localparam logic [2:0] ST_MAPPED  = 3'd6;

    localparam logic CFG_LOW  = 1'b0;
    localparam logic CFG_HIGH = 1'b1;

    typedef struct packed {
        logic [1:0]         command;
        logic [15:0]        sensor;
        logic [15:0]        room_id;
        logic signed [15:0] reading;
        logic [31:0]        stamp;
    } t_item;

    // lookup result carried down the row of entries
    typedef struct packed {
        logic               found;
        logic [15:0]        room;
        logic signed [15:0] avg;
        logic [31:0]        stamp;
    } t_link;

    typedef struct packed {
        logic map_wr;
        logic read_wr;
        logic avg_wr;
    } t_cell_ctl;

endpackage

// ===== rtl/psma_cell.sv =====
module psma_cell #(
    parameter int WINDOW_LEN = psma_pkg::DEF_WINDOW,
    localparam int SUM_W  = 17 + $clog2(WINDOW_LEN),
    localparam int FILL_W = $clog2(WINDOW_LEN + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_live,
    input  psma_pkg::t_item           i_key,
    input  psma_pkg::t_cell_ctl       i_ctl,
    input  logic signed [15:0]        i_avg,
    input  psma_pkg::t_link           i_link,
    input  logic signed [SUM_W-1:0]   i_sum,
    input  logic [FILL_W-1:0]         i_fill,
    output psma_pkg::t_link           o_link,
    output logic signed [SUM_W-1:0]   o_sum,
    output logic [FILL_W-1:0]         o_fill,
    output logic                      o_hit
);

    logic [15:0]              r_id;
    logic [15:0]              r_room;
    logic signed [15:0]       r_avg;
    logic [31:0]              r_time;
    logic [FILL_W-1:0]        r_fill;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [15:0]       r_win [WINDOW_LEN];

    logic                     w_full;
    logic signed [SUM_W-1:0]  w_val;
    logic signed [SUM_W-1:0]  w_drop;
    logic signed [SUM_W-1:0]  n_sum;
    logic [FILL_W-1:0]        n_fill;

    // running sum of the filled part of the window; oldest sample leaves once full
    always_comb begin
        w_full = (r_fill == FILL_W'(WINDOW_LEN));
        w_val  = {{(SUM_W-16){i_key.reading[15]}}, i_key.reading};
        w_drop = w_full ? {{(SUM_W-16){r_win[0][15]}}, r_win[0]} : '0;
        n_sum  = r_sum + w_val - w_drop;
        n_fill = w_full ? r_fill : r_fill + 1'b1;
    end

    always_comb begin
        o_hit = !i_link.found && i_live && (r_id == i_key.sensor);
        if (o_hit) begin
            o_link.found = 1'b1;
            o_link.room  = r_room;
            o_link.avg   = r_avg;
            o_link.stamp = r_time;
            o_sum        = n_sum;
            o_fill       = n_fill;
        end else begin
            o_link = i_link;
            o_sum  = i_sum;
            o_fill = i_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.map_wr) begin
            r_id   <= i_key.sensor;
            r_room <= i_key.room_id;
            r_avg  <= '0;
            r_time <= '0;
            r_fill <= '0;
            r_sum  <= '0;
        end else if (i_ctl.read_wr) begin
            r_time <= i_key.stamp;
            r_fill <= n_fill;
            r_sum  <= n_sum;
        end else if (i_ctl.avg_wr) begin
            r_avg <= i_avg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.read_wr) begin
            for (int k = 0; k < WINDOW_LEN - 1; k++) begin
                r_win[k] <= r_win[k+1];
            end
            r_win[WINDOW_LEN-1] <= i_key.reading;
        end
    end

endmodule

// ===== rtl/psma_div.sv =====
module psma_div #(
    parameter int WINDOW_LEN = psma_pkg::DEF_WINDOW,
    localparam int SUM_W    = 17 + $clog2(WINDOW_LEN),
    localparam int FILL_W   = $clog2(WINDOW_LEN + 1),
    localparam int STEP_W   = psma_pkg::DIV_STEP_BITS,
    localparam int DIV_ITER = (SUM_W + STEP_W - 1) / STEP_W,
    localparam int PAD_W    = DIV_ITER * STEP_W,
    localparam int CNT_W    = $clog2(DIV_ITER + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [SUM_W-1:0]  i_sum,
    input  logic [FILL_W-1:0]        i_fill,
    output logic                     o_done,
    output logic signed [15:0]       o_quot
);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [PAD_W-1:0]    r_dvd;
    logic [FILL_W-1:0]   r_rem;
    logic [FILL_W-1:0]   r_den;
    logic                r_neg;

    logic                w_neg;
    logic [SUM_W-1:0]    w_mag;
    logic [SUM_W-1:0]    w_num;
    logic [PAD_W-1:0]    n_dvd;
    logic [FILL_W-1:0]   n_rem;
    logic signed [15:0]  w_q;

    // round half away from zero: divide |sum| + n/2, then restore the sign
    always_comb begin
        w_neg = i_sum[SUM_W-1];
        w_mag = w_neg ? SUM_W'(-i_sum) : SUM_W'(i_sum);
        w_num = w_mag + SUM_W'(i_fill >> 1);
    end

    // restoring division, STEP_W quotient bits per cycle
    always_comb begin
        logic [FILL_W:0] t;
        n_dvd = r_dvd;
        n_rem = r_rem;
        for (int k = 0; k < STEP_W; k++) begin
            t     = {n_rem, n_dvd[PAD_W-1]};
            n_dvd = {n_dvd[PAD_W-2:0], 1'b0};
            if (t >= {1'b0, r_den}) begin
                n_rem    = FILL_W'(t - {1'b0, r_den});
                n_dvd[0] = 1'b1;
            end else begin
                n_rem = t[FILL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_ITER);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= PAD_W'(w_num);
            r_rem <= '0;
            r_den <= i_fill;
            r_neg <= w_neg;
        end else if (r_busy) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
        end
    end

    assign w_q    = r_dvd[15:0];
    assign o_quot = r_neg ? -w_q : w_q;
    assign o_done = r_done;

endmodule

// ===== rtl/per_sensor_moving_average_alarm.sv =====
// Channel   Direction  Handshake              Payload
// item      in         i_valid / o_stall      i_command, i_sensor, i_room_id, i_reading,
//                                             i_stamp
// result    out        o_valid / i_stall      o_sensor_out, o_room_out, o_average,
//                                             o_last_seen, o_status
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One word at a time. Map and query: the result is set by the lookup along the row of
// entry cells, registered in S_LOOK and loaded into the output register in S_OUT.
// Reading: set by the averaging divider in S_DIV at 4 quotient bits per cycle.
// o_stall is high from accept until the result is loaded into the output register.
// Synchronous active-low reset empties the table and restores both limits.
// While o_valid is stalled the result stays put; one more word can be taken and its
// result waits until the output register frees up.
module per_sensor_moving_average_alarm #(
    parameter int SENSOR_SLOTS = psma_pkg::DEF_SLOTS,
    parameter int WINDOW_LEN   = psma_pkg::DEF_WINDOW
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_command,
    input  logic [15:0]        i_sensor,
    input  logic [15:0]        i_room_id,
    input  logic signed [15:0] i_reading,
    input  logic [31:0]        i_stamp,

    output logic               o_valid,
    input  logic               i_stall,
    output logic [15:0]        o_sensor_out,
    output logic [15:0]        o_room_out,
    output logic signed [15:0] o_average,
    output logic [31:0]        o_last_seen,
    output logic [2:0]         o_status,

    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic signed [15:0] i_cfg_data
);

    localparam int SUM_W  = 17 + $clog2(WINDOW_LEN);
    localparam int FILL_W = $clog2(WINDOW_LEN + 1);
    localparam int CNT_W  = $clog2(SENSOR_SLOTS + 1);

    typedef enum logic [1:0] {S_IDLE, S_LOOK, S_DIV, S_OUT} t_state;

    t_state                   r_state;
    psma_pkg::t_item          r_item;
    logic [CNT_W-1:0]         r_count;
    logic signed [15:0]       r_low;
    logic signed [15:0]       r_high;
    logic [SENSOR_SLOTS-1:0]  r_sel;
    logic                     r_full;
    logic [15:0]              r_res_room;
    logic signed [15:0]       r_res_avg;
    logic [31:0]              r_res_time;
    logic [2:0]               r_res_status;

    psma_pkg::t_link          w_link [SENSOR_SLOTS+1];
    logic signed [SUM_W-1:0]  w_sum  [SENSOR_SLOTS+1];
    logic [FILL_W-1:0]        w_fill [SENSOR_SLOTS+1];
    logic [SENSOR_SLOTS-1:0]  w_hit;
    logic [SENSOR_SLOTS-1:0]  w_live;
    psma_pkg::t_cell_ctl      w_ctl  [SENSOR_SLOTS];
    logic                     w_found;
    logic                     w_room_left;
    logic                     w_div_start;
    logic                     w_div_done;
    logic signed [15:0]       w_quot;

    assign w_link[0]   = '0;
    assign w_sum[0]    = '0;
    assign w_fill[0]   = '0;
    assign w_found     = w_link[SENSOR_SLOTS].found;
    assign w_room_left = (r_count < CNT_W'(SENSOR_SLOTS));
    assign w_div_start = (r_state == S_LOOK) && (r_item.command == psma_pkg::CMD_READ)
                         && w_found;
    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        for (int i = 0; i < SENSOR_SLOTS; i++) begin
            w_live[i]         = (CNT_W'(i) < r_count);
            w_ctl[i].map_wr   = (r_state == S_LOOK) && (r_item.command == psma_pkg::CMD_MAP)
                                && (w_found ? w_hit[i]
                                            : (w_room_left && r_count == CNT_W'(i)));
            w_ctl[i].read_wr  = w_div_start && w_hit[i];
            w_ctl[i].avg_wr   = (r_state == S_DIV) && w_div_done && r_sel[i];
        end
    end

    for (genvar g = 0; g < SENSOR_SLOTS; g++) begin : g_cell
        psma_cell #(
            .WINDOW_LEN (WINDOW_LEN)
        ) u_cell (
            .i_clk  (i_clk),
            .i_live (w_live[g]),
            .i_key  (r_item),
            .i_ctl  (w_ctl[g]),
            .i_avg  (w_quot),
            .i_link (w_link[g]),
            .i_sum  (w_sum[g]),
            .i_fill (w_fill[g]),
            .o_link (w_link[g+1]),
            .o_sum  (w_sum[g+1]),
            .o_fill (w_fill[g+1]),
            .o_hit  (w_hit[g])
        );
    end

    psma_div #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_sum   (w_sum[SENSOR_SLOTS]),
        .i_fill  (w_fill[SENSOR_SLOTS]),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
            r_count <= '0;
            r_low   <= psma_pkg::LOW_RESET;
            r_high  <= psma_pkg::HIGH_RESET;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    psma_pkg::CFG_LOW:  r_low  <= i_cfg_data;
                    psma_pkg::CFG_HIGH: r_high <= i_cfg_data;
                    default: ;
                endcase
            end
            // S_OUT reloads the output register itself
            if (o_valid && !i_stall && r_state != S_OUT) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_item.command <= i_command;
                        r_item.sensor  <= i_sensor;
                        r_item.room_id <= i_room_id;
                        r_item.reading <= i_reading;
                        r_item.stamp   <= i_stamp;
                        r_state        <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    case (r_item.command)
                        psma_pkg::CMD_MAP: begin
                            r_res_avg  <= '0;
                            r_res_time <= '0;
                            r_state    <= S_OUT;
                            if (w_found || w_room_left) begin
                                r_res_room   <= r_item.room_id;
                                r_res_status <= psma_pkg::ST_MAPPED;
                                if (!w_found) begin
                                    r_count <= r_count + 1'b1;
                                end
                            end else begin
                                r_res_room   <= '0;
                                r_res_status <= psma_pkg::ST_FULL;
                            end
                        end
                        psma_pkg::CMD_READ: begin
                            if (w_found) begin
                                r_sel      <= w_hit;
                                r_full     <= (w_fill[SENSOR_SLOTS] == FILL_W'(WINDOW_LEN));
                                r_res_room <= w_link[SENSOR_SLOTS].room;
                                r_res_time <= r_item.stamp;
                                r_state    <= S_DIV;
                            end else begin
                                r_res_room   <= '0;
                                r_res_avg    <= '0;
                                r_res_time   <= '0;
                                r_res_status <= psma_pkg::ST_UNKNOWN;
                                r_state      <= S_OUT;
                            end
                        end
                        psma_pkg::CMD_QUERY: begin
                            r_state <= S_OUT;
                            if (w_found) begin
                                r_res_room   <= w_link[SENSOR_SLOTS].room;
                                r_res_avg    <= w_link[SENSOR_SLOTS].avg;
                                r_res_time   <= w_link[SENSOR_SLOTS].stamp;
                                r_res_status <= psma_pkg::ST_OK;
                            end else begin
                                r_res_room   <= '0;
                                r_res_avg    <= '0;
                                r_res_time   <= '0;
                                r_res_status <= psma_pkg::ST_UNKNOWN;
                            end
                        end
                        default: begin
                            r_res_room   <= '0;
                            r_res_avg    <= '0;
                            r_res_time   <= '0;
                            r_res_status <= psma_pkg::ST_UNKNOWN;
                            r_state      <= S_OUT;
                        end
                    endcase
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_res_avg <= w_quot;
                        if (!r_full) begin
                            r_res_status <= psma_pkg::ST_FILLING;
                        end else if (w_quot < r_low) begin
                            r_res_status <= psma_pkg::ST_COLD;
                        end else if (w_quot > r_high) begin
                            r_res_status <= psma_pkg::ST_HOT;
                        end else begin
                            r_res_status <= psma_pkg::ST_OK;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!o_valid || !i_stall) begin
                        o_valid      <= 1'b1;
                        o_sensor_out <= r_item.sensor;
                        o_room_out   <= r_res_room;
                        o_average    <= r_res_avg;
                        o_last_seen  <= r_res_time;
                        o_status     <= r_res_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/psma_chk.sv =====
module psma_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic [15:0]        o_room_out,
    input logic signed [15:0] o_average,
    input logic [31:0]        o_last_seen,
    input logic [2:0]         o_status
);

    // one word in flight: a taken word blocks the input on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after accepting a word");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_average))
        else $error("stalled result changed");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == psma_pkg::ST_UNKNOWN || o_status == psma_pkg::ST_FULL)
        |-> o_room_out == 16'd0 && o_average == 16'sd0 && o_last_seen == 32'd0)
        else $error("miss or full result carries data");

    a_map_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == psma_pkg::ST_MAPPED
        |-> o_average == 16'sd0 && o_last_seen == 32'd0)
        else $error("mapped result not cleared");

endmodule

bind per_sensor_moving_average_alarm psma_chk u_psma_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_room_out  (o_room_out),
    .o_average   (o_average),
    .o_last_seen (o_last_seen),
    .o_status    (o_status)
);
